// ===== sv/bps_pkg.sv =====
// Shared types, constants and constant functions of the Bernoulli peak sampler.
package bps_pkg;

	// Request codes carried in the func field.
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// Lehmer generator: multiplier and prime modulus 2^32 - 5.
	localparam logic [31:0] LCG_MULT = 32'd279470273;
	localparam logic [31:0] LCG_MOD  = 32'd4294967291;

	// Probability scale of the thresholds.
	localparam logic [16:0] PROB_SCALE = 17'd100000;

	// Reciprocal of the scale for the residue: floor(2^48 / 100000).
	localparam int unsigned   RECIP_SHIFT = 48;
	localparam logic [63:0]   RECIP_WIDE  = (64'd1 << RECIP_SHIFT) / 64'(PROB_SCALE);
	localparam logic [31:0]   RECIP_MULT  = RECIP_WIDE[31:0];

	// One input request.
	typedef struct packed {
		logic        func;
		logic [15:0] bin;
		logic [16:0] threshold;
		logic        last_in_list;
	} in_item_t;

	// One result.
	typedef struct packed {
		logic        picked;
		logic [15:0] out_bin;
		logic        skipped;
		logic        list_end;
	} out_item_t;

	// Generator value after n steps from the seed one, for elaboration only.
	function automatic logic [31:0] lcg_power(input int unsigned n);
		logic [63:0] x;
		x = 64'd1;
		for (int unsigned i = 0; i < n; i++) begin
			x = (x * 64'(LCG_MULT)) % 64'(LCG_MOD);
		end
		return x[31:0];
	endfunction

	// The generator loop holds three values in flight, so it steps by three.
	localparam logic [31:0] RNG_S1   = lcg_power(1);
	localparam logic [31:0] RNG_S2   = lcg_power(2);
	localparam logic [31:0] RNG_S3   = lcg_power(3);
	localparam logic [31:0] RNG_JUMP = lcg_power(3);

endpackage

// ===== sv/bps_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module bps_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 16384
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/bernoulli_peak_sampler_core.sv =====
// Top level of the Bernoulli peak sampler: table RAM, generator loop and sample pipeline.
//
// The block takes one request per cycle while in_ready is high and gives one result per
// sample request through stages s1, s2 and s3 and the output register; load requests
// give no result. An in-range load writes the threshold table at its acceptance edge, so
// a sample of the same bin in the very next cycle already reads the new value. The rate is
// set by the single-port table read, one per cycle, and by the three-stage multiply and
// reduce loop of the Lehmer generator, which keeps three successive generator values in
// flight and steps each by the third power of the multiplier, so one draw is ready every
// cycle. The table needs no clearing pass after reset; an entry must be loaded before it is
// sampled. While a result waits at the output, the whole pipeline holds and in_ready is low.
module bernoulli_peak_sampler_core #(
	parameter int MAX_BINS = 16384
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [14:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  bps_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bps_pkg::out_item_t out_data
);

	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

	// Configuration and list state.
	logic [14:0] num_bins_q;
	logic        list_stopped_q;

	// Generator loop: product, folded sum and current value.
	logic [63:0] ring_p_q;
	logic [34:0] ring_t_q;
	logic [31:0] ring_q;
	logic [34:0] ring_fold;
	logic [32:0] ring_u;
	logic [31:0] ring_next;

	// Input decode.
	logic        adv;
	logic        accept;
	logic        is_sample;
	logic        is_load;
	logic [16:0] active_bins;
	logic        in_range;
	logic        skip;
	logic        draw;
	logic [16:0] thr_sat;

	// Pipeline stages.
	logic        v_s1, v_s2, v_s3;
	logic [15:0] bin_s1, bin_s2, bin_s3;
	logic        last_s1, last_s2, last_s3;
	logic        skip_s1, skip_s2, skip_s3;
	logic [31:0] rnd_s1, rnd_s2;
	logic [63:0] prod_s2;
	logic [16:0] thr_s2, thr_s3;
	logic [17:0] r0_s3;
	logic [16:0] thr_rd;
	logic [15:0] quot;
	logic [31:0] quot_x_scale;
	logic [31:0] r0_full;
	logic [17:0] resid;
	logic        picked;

	logic               out_valid_q;
	bps_pkg::out_item_t out_data_q;

	// The pipeline moves whenever the output register is free or being emptied.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	// Range check against the effective bin count.
	always_comb begin
		if (17'(num_bins_q) < 17'(MAX_BINS)) begin
			active_bins = 17'(num_bins_q);
		end else begin
			active_bins = 17'(MAX_BINS);
		end
	end

	assign is_sample = accept && (in_data.func == bps_pkg::FUNC_SAMPLE);
	assign is_load   = accept && (in_data.func == bps_pkg::FUNC_LOAD);
	assign in_range  = 17'(in_data.bin) < active_bins;
	assign skip      = list_stopped_q || !in_range;
	assign draw      = is_sample && !skip;
	assign thr_sat   = (in_data.threshold > bps_pkg::PROB_SCALE) ?
		bps_pkg::PROB_SCALE : in_data.threshold;

	// Threshold table.
	bps_ram #(
		.WIDTH(17),
		.DEPTH(MAX_BINS)
	) u_table (
		.clk  (clk),
		.we   (is_load && in_range),
		.waddr(in_data.bin[AW-1:0]),
		.wdata(thr_sat),
		.re   (is_sample),
		.raddr(in_data.bin[AW-1:0]),
		.rdata(thr_rd)
	);

	// Configuration register and list-stop flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q     <= '0;
			list_stopped_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_bins_q <= cfg_wdata;
			end
			if (is_sample) begin
				list_stopped_q <= in_data.last_in_list ? 1'b0 : skip;
			end
		end
	end

	// Modular reduction by 2^32 - 5: fold the high word in twice, then one subtract.
	assign ring_fold = (35'(ring_p_q[63:32]) << 2) + 35'(ring_p_q[63:32]) + 35'(ring_p_q[31:0]);
	assign ring_u    = 33'(ring_t_q[31:0]) + (33'(ring_t_q[34:32]) << 2) + 33'(ring_t_q[34:32]);
	assign ring_next = (ring_u >= 33'(bps_pkg::LCG_MOD)) ?
		32'(ring_u - 33'(bps_pkg::LCG_MOD)) : ring_u[31:0];

	// Generator loop, advanced once per draw.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_p_q <= 64'(bps_pkg::RNG_S3);
			ring_t_q <= 35'(bps_pkg::RNG_S2);
			ring_q   <= bps_pkg::RNG_S1;
		end else if (draw) begin
			ring_p_q <= 64'(ring_q) * 64'(bps_pkg::RNG_JUMP);
			ring_t_q <= ring_fold;
			ring_q   <= ring_next;
		end
	end

	// Residue by reciprocal multiply: the quotient estimate is exact or one low.
	assign quot         = prod_s2[63:48];
	assign quot_x_scale = 32'(33'(quot) * 33'(bps_pkg::PROB_SCALE));
	assign r0_full      = rnd_s2 - quot_x_scale;
	assign resid        = (r0_s3 >= 18'(bps_pkg::PROB_SCALE)) ?
		r0_s3 - 18'(bps_pkg::PROB_SCALE) : r0_s3;
	assign picked       = !skip_s3 && (resid < 18'(thr_s3));

	// Valid bits of the sample pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= is_sample;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Payload of the sample pipeline.
	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s1  <= in_data.bin;
			last_s1 <= in_data.last_in_list;
			skip_s1 <= skip;
			rnd_s1  <= ring_q;

			bin_s2  <= bin_s1;
			last_s2 <= last_s1;
			skip_s2 <= skip_s1;
			rnd_s2  <= rnd_s1;
			prod_s2 <= 64'(rnd_s1) * 64'(bps_pkg::RECIP_MULT);
			thr_s2  <= thr_rd;

			bin_s3  <= bin_s2;
			last_s3 <= last_s2;
			skip_s3 <= skip_s2;
			r0_s3   <= r0_full[17:0];
			thr_s3  <= thr_s2;

			out_data_q.picked   <= picked;
			out_data_q.out_bin  <= bin_s3;
			out_data_q.skipped  <= skip_s3;
			out_data_q.list_end <= last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== sv/bps_checker.sv =====
// Port-level assertions for the Bernoulli peak sampler and their bind.
module bps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input bps_pkg::out_item_t out_data
);

	// A stalled result stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// Input back-pressure only comes from a result that is not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

	// A skipped sample is never reported as picked.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.picked && out_data.skipped))
		else $error("skipped result marked picked");

	// An empty output never holds off the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |=> $past(in_ready))
		else $error("input stalled while output was empty");

endmodule

bind bernoulli_peak_sampler_core bps_checker u_bps_checker (.*);
